FILE: sv/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants for the cell balance marker.
// ----------------------------------------------------------------------------
`default_nettype none

package cbm_pkg;

  localparam logic [15:0] THRESH_RST = 16'd200;
  localparam logic [15:0] MIN_RST    = 16'hFFFF;

  localparam logic KIND_FLAG = 1'b0;
  localparam logic KIND_PACK = 1'b1;

  // one classified cell word handed from front to back
  typedef struct packed {
    logic [15:0] voltage;
    logic [15:0] minimum;    // module minimum including this cell
    logic [3:0]  module_num;
    logic [4:0]  cell_num;
    logic        start;      // first cell of a pack scan
    logic        end_mod;    // last cell of its module
    logic        end_pack;   // last cell of the pack
  } cbm_entry_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_EMIT,
    B_PACK
  } cbm_bstate_t;

endpackage

`default_nettype wire

FILE: sv/cell_balance_marker.sv
// Flow: the back pops a module's cell words from the two-entry queue into the cell buffer,
// reads the buffer in B_READ, then sends N flag words from B_EMIT, one per cycle while the
// output is not stalled, and a pack report after the last module of a pack. No cell word is
// popped while a module is being flagged; the front stalls while the queue is full.
// Reset is synchronous, active low: threshold 200, counters and worst cell cleared,
// minimum all ones; the cell buffer is not cleared.
// ----------------------------------------------------------------------------
// cell_balance_marker
// Passive cell balancing decision: per-cell bleed flags and pack worst cell.
// ----------------------------------------------------------------------------
`default_nettype none

module cell_balance_marker #(
  parameter int MODULE_COUNT    = 6,
  parameter int CELLS_IN_MODULE = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] cell voltage
  input  wire logic [0:0]  in_tuser,   // [0] start_of_pack
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [3:0] module_number, [8:4] cell_number,
                                       // [9] needs_balance, [25:10] excess_voltage
  output logic [0:0]       out_tuser,  // [0] report_kind
  output logic             out_tlast,  // last_of_burst
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data // bleed threshold
);
  import cbm_pkg::*;

  logic [15:0] threshold_r;
  logic        q_push, q_full, q_valid, q_pop;
  cbm_entry_t  push_entry, head_entry;

  logic        o_kind, o_needs;
  logic [3:0]  o_module;
  logic [4:0]  o_cell;
  logic [15:0] o_excess;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESH_RST;
    end else if (cfg_wr_en) begin
      threshold_r <= cfg_wr_data;
    end
  end

  cbm_front #(
    .MODULE_COUNT    (MODULE_COUNT),
    .CELLS_IN_MODULE (CELLS_IN_MODULE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .voltage  (in_tdata),
    .start    (in_tuser[0]),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_entry  (push_entry)
  );

  cbm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (head_entry)
  );

  cbm_back #(
    .CELLS_IN_MODULE (CELLS_IN_MODULE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .threshold  (threshold_r),
    .q_valid    (q_valid),
    .q_entry    (head_entry),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (o_kind),
    .out_module (o_module),
    .out_cell   (o_cell),
    .out_needs  (o_needs),
    .out_excess (o_excess),
    .out_last   (out_tlast)
  );

  assign out_tdata = {6'd0, o_excess, o_needs, o_cell, o_module};
  assign out_tuser = o_kind;

endmodule

`default_nettype wire

FILE: sv/cbm_front.sv
// ----------------------------------------------------------------------------
// cbm_front
// Accepts cell words, keeps cell/module position and the module minimum.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_front #(
  parameter int MODULE_COUNT    = 6,
  parameter int CELLS_IN_MODULE = 12
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [15:0]        voltage,
  input  wire logic               start,
  output logic                    q_push,
  input  wire logic               q_full,
  output cbm_pkg::cbm_entry_t     q_entry
);
  import cbm_pkg::*;

  localparam int CIDX_W = (CELLS_IN_MODULE > 1) ? $clog2(CELLS_IN_MODULE) : 1;
  localparam int MIDX_W = (MODULE_COUNT > 1) ? $clog2(MODULE_COUNT) : 1;
  localparam logic [CIDX_W-1:0] CELL_LAST = CIDX_W'(CELLS_IN_MODULE - 1);
  localparam logic [MIDX_W-1:0] MOD_LAST  = MIDX_W'(MODULE_COUNT - 1);

  logic [CIDX_W-1:0] cell_cnt_r, cell_cnt_nxt, cell_eff;
  logic [MIDX_W-1:0] mod_cnt_r, mod_cnt_nxt, mod_eff;
  logic [15:0]       min_r, min_nxt, min_eff, min_new;
  logic              end_mod, end_pack;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    // start of pack restarts position and minimum before the cell is taken
    cell_eff = start ? '0 : cell_cnt_r;
    mod_eff  = start ? '0 : mod_cnt_r;
    min_eff  = start ? MIN_RST : min_r;
    min_new  = (voltage < min_eff) ? voltage : min_eff;
    end_mod  = (cell_eff == CELL_LAST);
    end_pack = end_mod && (mod_eff == MOD_LAST);

    q_entry.voltage    = voltage;
    q_entry.minimum    = min_new;
    q_entry.module_num = 4'(mod_eff);
    q_entry.cell_num   = 5'(cell_eff);
    q_entry.start      = start;
    q_entry.end_mod    = end_mod;
    q_entry.end_pack   = end_pack;

    if (end_mod) begin
      cell_cnt_nxt = '0;
      min_nxt      = MIN_RST;
      mod_cnt_nxt  = end_pack ? '0 : mod_eff + 1'b1;
    end else begin
      cell_cnt_nxt = cell_eff + 1'b1;
      min_nxt      = min_new;
      mod_cnt_nxt  = mod_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_cnt_r <= '0;
      mod_cnt_r  <= '0;
      min_r      <= MIN_RST;
    end else if (q_push) begin
      cell_cnt_r <= cell_cnt_nxt;
      mod_cnt_r  <= mod_cnt_nxt;
      min_r      <= min_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/cbm_queue.sv
// ----------------------------------------------------------------------------
// cbm_queue
// Two-entry queue of classified cell words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire cbm_pkg::cbm_entry_t push_entry,
  output logic                     full,
  input  wire logic                pop,
  output logic                     valid,
  output cbm_pkg::cbm_entry_t      head
);
  import cbm_pkg::*;

  cbm_entry_t slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full  = (count_r == 2'd2);
  assign valid = (count_r != 2'd0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

FILE: sv/cbm_back.sv
// ----------------------------------------------------------------------------
// cbm_back
// Buffers a module's cells, then walks them out as balance flags and keeps
// the pack-wide worst cell for the pack report.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_back #(
  parameter int CELLS_IN_MODULE = 12
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [15:0]         threshold,
  input  wire logic                q_valid,
  input  wire cbm_pkg::cbm_entry_t q_entry,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_kind,
  output logic [3:0]               out_module,
  output logic [4:0]               out_cell,
  output logic                     out_needs,
  output logic [15:0]              out_excess,
  output logic                     out_last
);
  import cbm_pkg::*;

  localparam int CIDX_W = (CELLS_IN_MODULE > 1) ? $clog2(CELLS_IN_MODULE) : 1;
  localparam logic [CIDX_W-1:0] CELL_LAST = CIDX_W'(CELLS_IN_MODULE - 1);

  logic [15:0] cell_mem [CELLS_IN_MODULE];
  logic [15:0] rd_data_r;

  cbm_bstate_t       state_r, state_nxt;
  logic [CIDX_W-1:0] idx_r, rd_addr;
  logic [15:0]       min_r;
  logic [3:0]        mod_r;
  logic              last_pack_r;
  logic [15:0]       worst_ex_r;
  logic [3:0]        worst_mod_r;
  logic [4:0]        worst_cidx_r;

  logic              out_valid_r, out_kind_r, out_needs_r, out_last_r;
  logic [3:0]        out_module_r;
  logic [4:0]        out_cell_r;
  logic [15:0]       out_excess_r;

  logic        out_free, flag_fire, pack_fire;
  logic [15:0] excess;

  assign out_free = !out_valid_r || out_ready;
  assign excess   = rd_data_r - min_r;

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    flag_fire = 1'b0;
    pack_fire = 1'b0;
    rd_addr   = idx_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_entry.end_mod) state_nxt = B_READ;
        end
      end
      B_READ: state_nxt = B_EMIT;
      B_EMIT: begin
        if (out_free) begin
          flag_fire = 1'b1;
          if (idx_r == CELL_LAST) begin
            state_nxt = last_pack_r ? B_PACK : B_IDLE;
          end else begin
            // fetch the next cell while this one goes out
            rd_addr = idx_r + 1'b1;
          end
        end
      end
      B_PACK: begin
        if (out_free) begin
          pack_fire = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cell_mem[q_entry.cell_num[CIDX_W-1:0]] <= q_entry.voltage;
    end
    rd_data_r <= cell_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      worst_ex_r   <= '0;
      worst_mod_r  <= '0;
      worst_cidx_r <= '0;
    end else begin
      if (q_pop) begin
        if (q_entry.start) begin
          worst_ex_r   <= '0;
          worst_mod_r  <= '0;
          worst_cidx_r <= '0;
        end
        if (q_entry.end_mod) begin
          idx_r       <= '0;
          min_r       <= q_entry.minimum;
          mod_r       <= q_entry.module_num;
          last_pack_r <= q_entry.end_pack;
        end
      end
      if (flag_fire) begin
        idx_r <= rd_addr;
        // only a strictly larger excess takes over
        if (excess > worst_ex_r) begin
          worst_ex_r   <= excess;
          worst_mod_r  <= mod_r;
          worst_cidx_r <= 5'(idx_r);
        end
      end
      if (pack_fire) begin
        worst_ex_r   <= '0;
        worst_mod_r  <= '0;
        worst_cidx_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (flag_fire || pack_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (flag_fire) begin
      out_kind_r   <= KIND_FLAG;
      out_module_r <= mod_r;
      out_cell_r   <= 5'(idx_r);
      out_needs_r  <= (excess > threshold);
      out_excess_r <= excess;
      out_last_r   <= (idx_r == CELL_LAST) && !last_pack_r;
    end else if (pack_fire) begin
      out_kind_r   <= KIND_PACK;
      out_module_r <= worst_mod_r;
      out_cell_r   <= worst_cidx_r;
      out_needs_r  <= (worst_ex_r > threshold);
      out_excess_r <= worst_ex_r;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_module = out_module_r;
  assign out_cell   = out_cell_r;
  assign out_needs  = out_needs_r;
  assign out_excess = out_excess_r;
  assign out_last   = out_last_r;

  a_pack_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_PACK)) |-> out_last_r)
    else $error("pack report without end of burst");

  a_pack_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_PACK) |-> last_pack_r)
    else $error("pack report state outside the last module");

  a_no_pop_while_scanning: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == B_IDLE))
    else $error("queue popped while a module is being flagged");

  a_burst_end_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (flag_fire && (idx_r == CELL_LAST) && !last_pack_r) |=> (state_r == B_IDLE))
    else $error("flag burst did not return to idle");

endmodule

`default_nettype wire

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for cell_balance_marker: cell words go in on the stream
// input, a predictor in the scoreboard works out every flag and pack report,
// and each result word is checked in order under random back-pressure.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic        kind;
  logic [3:0]  module_num;
  logic [4:0]  cell_num;
  logic        flag;
  logic [15:0] excess;
  logic        last;
} balance_report_t;

class balance_scoreboard #(int MODS = 6, int CELLS = 12);
  logic [15:0]     threshold;
  logic [15:0]     cell_store [CELLS];
  logic [15:0]     mod_floor;
  int unsigned     cell_pos;
  int unsigned     mod_pos;
  logic [15:0]     worst_excess;
  logic [3:0]      worst_mod;
  logic [4:0]      worst_cidx;
  balance_report_t pending_reports [$];
  int              errors;

  function new();
    threshold = cbm_pkg::THRESH_RST;
    mod_floor = cbm_pkg::MIN_RST;
    cell_pos  = 0;
    mod_pos   = 0;
    errors    = 0;
    clear_worst();
  endfunction

  function void clear_worst();
    worst_excess = '0;
    worst_mod    = '0;
    worst_cidx   = '0;
  endfunction

  // accepted cell word: gather the module and queue its burst when complete
  function void note_cell(logic [15:0] voltage, logic sop);
    balance_report_t r;
    logic [15:0]     ex;
    if (sop) begin
      cell_pos  = 0;
      mod_pos   = 0;
      mod_floor = cbm_pkg::MIN_RST;
      clear_worst();
    end
    cell_store[cell_pos] = voltage;
    if (voltage < mod_floor) mod_floor = voltage;
    if (cell_pos + 1 < CELLS) begin
      cell_pos++;
      return;
    end
    for (int i = 0; i < CELLS; i++) begin
      ex           = cell_store[i] - mod_floor;
      r.kind       = cbm_pkg::KIND_FLAG;
      r.module_num = 4'(mod_pos);
      r.cell_num   = 5'(i);
      r.flag       = (ex > threshold);
      r.excess     = ex;
      r.last       = (i == CELLS - 1) && (mod_pos + 1 < MODS);
      pending_reports.push_back(r);
      // only a strictly larger excess takes over
      if (ex > worst_excess) begin
        worst_excess = ex;
        worst_mod    = 4'(mod_pos);
        worst_cidx   = 5'(i);
      end
    end
    cell_pos  = 0;
    mod_floor = cbm_pkg::MIN_RST;
    if (mod_pos + 1 < MODS) begin
      mod_pos++;
    end else begin
      r.kind       = cbm_pkg::KIND_PACK;
      r.module_num = worst_mod;
      r.cell_num   = worst_cidx;
      r.flag       = (worst_excess > threshold);
      r.excess     = worst_excess;
      r.last       = 1'b1;
      pending_reports.push_back(r);
      mod_pos = 0;
      clear_worst();
    end
  endfunction

  function void compare(string what, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  function void check_report(logic [31:0] data, logic [0:0] user, logic last);
    balance_report_t e;
    if (pending_reports.size() == 0) begin
      $display("%0t: unexpected result word: expected none, actual data %h kind %0d",
               $time, data, user);
      errors++;
      return;
    end
    e = pending_reports.pop_front();
    compare("report_kind", 16'(e.kind), 16'(user[0]));
    compare("module_number", 16'(e.module_num), 16'(data[3:0]));
    compare("cell_number", 16'(e.cell_num), 16'(data[8:4]));
    compare("needs_balance", 16'(e.flag), 16'(data[9]));
    compare("excess_voltage", e.excess, data[25:10]);
    compare("last_of_burst", 16'(e.last), 16'(last));
  endfunction
endclass

module tb;
  localparam int MODULES     = 6;
  localparam int CELLS       = 12;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_GAP   = 16;
  localparam int HOLD_CYCLES = 250;

  typedef enum {PACK_NARROW, PACK_WIDE, PACK_FLAT} pack_style_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  balance_scoreboard #(.MODS(MODULES), .CELLS(CELLS)) sb;

  int          send_idle_pct;
  int          rcv_idle_pct;
  bit          want_pressure;
  bit          pressure_given;
  int          hold_left;

  // random pack generator state
  int          pack_pos;
  int          packs_begun;
  pack_style_t style;
  logic [15:0] module_base;

  cell_balance_marker #(
    .MODULE_COUNT    (MODULES),
    .CELLS_IN_MODULE (CELLS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_cell(logic [15:0] voltage, logic sop);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= voltage;
    in_tuser  <= sop;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_cell(voltage, sop);
  endtask

  task automatic write_threshold(logic [15:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.threshold = value;
  endtask

  task automatic wait_drained();
    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // mostly whole packs with random content; a few restarts and stray words
  task automatic random_cells(int count);
    logic [15:0] v;
    logic        sop;
    for (int k = 0; k < count; k++) begin
      sop = 1'b0;
      if (pack_pos != 0 && style != PACK_FLAT && $urandom_range(99) < 3) begin
        pack_pos = 0;
        sop      = 1'b1;
      end
      if (pack_pos == 0) begin
        if (!sop) sop = ($urandom_range(3) != 0);
        if (packs_begun == 1) style = PACK_FLAT;
        else style = ($urandom_range(2) == 0) ? PACK_WIDE : PACK_NARROW;
        packs_begun++;
      end
      if (pack_pos % CELLS == 0) module_base = 16'($urandom_range(30000, 42000));
      case (style)
        PACK_FLAT:   v = module_base;
        PACK_NARROW: v = module_base + 16'($urandom_range(0, 21) * 20);
        default:     v = 16'($urandom);
      endcase
      if (style != PACK_FLAT && $urandom_range(99) < 4) v = 16'($urandom);
      send_cell(v, sop);
      pack_pos = (pack_pos + 1) % (MODULES * CELLS);
    end
  endtask

  task automatic run_phase(logic [15:0] thresh, int s_idle, int r_idle, int count);
    write_threshold(thresh);
    send_idle_pct = s_idle;
    rcv_idle_pct  = r_idle;
    random_cells(count);
    in_tvalid <= 1'b0;
    wait_drained();
  endtask

  // result side: check on handshake, then pick tready for the next cycle
  initial begin
    out_tready     = 1'b0;
    pressure_given = 1'b0;
    hold_left      = 0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1)
        sb.check_report(out_tdata, out_tuser, out_tlast);
      if (want_pressure && !pressure_given) begin
        hold_left      = HOLD_CYCLES;
        pressure_given = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [15:0] extreme_cells [CELLS];
    extreme_cells = '{16'd0, 16'hFFFF, 16'd200, 16'd201, 16'd199, 16'h5555,
                      16'hAAAA, 16'd1, 16'h8000, 16'h7FFF, 16'd0, 16'd150};
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    send_idle_pct = 9;
    rcv_idle_pct  = 58;
    want_pressure = 1'b0;
    pack_pos      = 0;
    packs_begun   = 0;
    style         = PACK_NARROW;
    module_base   = '0;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // threshold left at its reset value; a partial module is dropped by the restart
    for (int i = 0; i < 4; i++) send_cell(16'(1000 + 300 * i), 1'b0);
    // excess of exactly the threshold stays unflagged, one more is flagged
    for (int i = 0; i < CELLS; i++) send_cell(extreme_cells[i], (i == 0));
    for (int i = 0; i < 8; i++) send_cell(i[0] ? 16'hFFFF : 16'h0000, 1'b0);
    in_tvalid <= 1'b0;
    wait_drained();

    run_phase(16'd0, 9, 58, 86);
    run_phase(16'hFFFF, 58, 9, 86);
    want_pressure = 1'b1;
    run_phase(16'($urandom_range(1, 400)), 0, 0, 86);

    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
